>>> design/fbs_pkg.sv
// Shared constants, register codes and types of the frame byte stuffer.
package fbs_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned HDR_POS_W    = 3;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);

  localparam logic [BYTE_W-1:0] FLAG_RESET         = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET       = 8'd125;
  localparam logic [BYTE_W-1:0] FLAG_SUBST_RESET   = 8'd94;
  localparam logic [BYTE_W-1:0] ESCAPE_SUBST_RESET = 8'd93;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLAG         = 2'd0,
    CFG_ESCAPE       = 2'd1,
    CFG_FLAG_SUBST   = 2'd2,
    CFG_ESCAPE_SUBST = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] flag_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] flag_substitute;
    logic [BYTE_W-1:0] escape_substitute;
  } cfg_t;

  // One classified input byte: the bytes to send and whether there are two.
  typedef struct packed {
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic              two;
    logic              frame_end;
  } item_t;

  // Handshake between two internal stages.
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

>>> design/fbs_in_if.sv
// Input channel: one unstuffed frame byte per transfer.
interface fbs_in_if;
  logic                      valid;
  logic                      ready;
  logic [fbs_pkg::BYTE_W-1:0] in_byte;
  logic                      in_frame_end;

  modport source (output valid, output in_byte, output in_frame_end, input ready);
  modport sink (input valid, input in_byte, input in_frame_end, output ready);
endinterface

>>> design/fbs_out_if.sv
// Output channel: one stuffed frame byte per transfer.
interface fbs_out_if;
  logic                      valid;
  logic                      ready;
  logic [fbs_pkg::BYTE_W-1:0] out_byte;
  logic                      out_frame_end;
  logic                      run_end;

  modport source (output valid, output out_byte, output out_frame_end, output run_end,
                  input ready);
  modport sink (input valid, input out_byte, input out_frame_end, input run_end,
                output ready);
endinterface

>>> design/fbs_front.sv
// Front stage: accepts input bytes, tracks the header position and classifies each byte.
module fbs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbs_pkg::cfg_t      cfg_i,
  fbs_in_if.sink             in_i,
  output fbs_pkg::hs_t       push_hs_o,
  input  logic               push_ready_i,
  output fbs_pkg::item_t     push_item_o
);

  logic [fbs_pkg::HDR_POS_W-1:0] hdr_pos_q, hdr_pos_d;
  logic                          in_header;
  logic                          accept;

  assign in_header = hdr_pos_q < fbs_pkg::HDR_POS_W'(fbs_pkg::HEADER_BYTES);
  assign accept    = in_i.valid & push_ready_i;

  assign in_i.ready      = push_ready_i;
  assign push_hs_o.valid = in_i.valid;
  assign push_hs_o.ready = push_ready_i;

  always_comb begin
    push_item_o.first_byte  = in_i.in_byte;
    push_item_o.second_byte = cfg_i.flag_substitute;
    push_item_o.two         = 1'b0;
    push_item_o.frame_end   = in_i.in_frame_end;
    hdr_pos_d               = hdr_pos_q;
    if (in_i.in_frame_end) begin
      hdr_pos_d = '0;
    end else if (in_header) begin
      hdr_pos_d = hdr_pos_q + fbs_pkg::HDR_POS_W'(1);
    end else if (in_i.in_byte == cfg_i.flag_byte) begin
      // A flag match wins when flag and escape hold the same value.
      push_item_o.first_byte  = cfg_i.escape_byte;
      push_item_o.second_byte = cfg_i.flag_substitute;
      push_item_o.two         = 1'b1;
    end else if (in_i.in_byte == cfg_i.escape_byte) begin
      push_item_o.first_byte  = cfg_i.escape_byte;
      push_item_o.second_byte = cfg_i.escape_substitute;
      push_item_o.two         = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q <= '0;
    end else if (accept) begin
      hdr_pos_q <= hdr_pos_d;
    end
  end

endmodule

>>> design/fbs_queue.sv
// Short queue of classified bytes between the front and back stages.
module fbs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  fbs_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output fbs_pkg::item_t pop_item_o
);

  fbs_pkg::item_t                 mem_q [fbs_pkg::QUEUE_DEPTH];
  logic [fbs_pkg::QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [fbs_pkg::QUEUE_AW:0]     count_q;
  logic                           push, pop;

  assign push_ready_o = count_q != (fbs_pkg::QUEUE_AW+1)'(fbs_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == fbs_pkg::QUEUE_AW'(fbs_pkg::QUEUE_DEPTH - 1)) ? '0
                  : wr_ptr_q + fbs_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == fbs_pkg::QUEUE_AW'(fbs_pkg::QUEUE_DEPTH - 1)) ? '0
                  : rd_ptr_q + fbs_pkg::QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (fbs_pkg::QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (fbs_pkg::QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

>>> design/fbs_back.sv
// Back stage: expands each classified byte into one or two output transfers.
module fbs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  fbs_pkg::item_t pop_item_i,
  fbs_out_if.source      out_o
);

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } phase_e;

  phase_e                     phase_q;
  logic                       out_valid_q;
  logic [fbs_pkg::BYTE_W-1:0] out_byte_q, second_byte_q;
  logic                       frame_end_q, run_end_q;
  logic                       load;

  // The output register may be refilled when empty or while being drained.
  assign load        = !out_valid_q || out_o.ready;
  assign pop_ready_o = load && (phase_q == PH_FIRST);

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.out_frame_end = frame_end_q;
  assign out_o.run_end       = run_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_FIRST;
      out_valid_q   <= 1'b0;
      out_byte_q    <= '0;
      second_byte_q <= '0;
      frame_end_q   <= 1'b0;
      run_end_q     <= 1'b0;
    end else if (load) begin
      case (phase_q)
        PH_SECOND: begin
          out_valid_q <= 1'b1;
          out_byte_q  <= second_byte_q;
          frame_end_q <= 1'b0;
          run_end_q   <= 1'b1;
          phase_q     <= PH_FIRST;
        end
        PH_FIRST: begin
          out_valid_q <= pop_valid_i;
          if (pop_valid_i) begin
            out_byte_q    <= pop_item_i.first_byte;
            second_byte_q <= pop_item_i.second_byte;
            frame_end_q   <= pop_item_i.frame_end;
            run_end_q     <= !pop_item_i.two;
            phase_q       <= pop_item_i.two ? PH_SECOND : PH_FIRST;
          end
        end
        default: begin
          phase_q     <= PH_FIRST;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> design/frame_byte_stuffer_unit.sv
// Top level of the frame byte stuffer: configuration registers and the stage wiring.
//
//   channel   direction  payload                               transfer when
//   in_i      in         in_byte[7:0], in_frame_end            valid & ready
//   out_o     out        out_byte[7:0], out_frame_end, run_end valid & ready
//   cfg       in         cfg_idx_i[1:0], cfg_data_i[7:0]       cfg_we_i
//
// A plain byte passes through the queue and the output register, one byte per cycle
// while the output is ready. An escaped byte gives two output transfers; the
// two-entry queue holds input meanwhile; input stalls only when the queue is full.
// Reset clears the header position, the queue and the output register, and loads the
// default special byte values.
module frame_byte_stuffer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fbs_in_if.sink                        in_i,
  fbs_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [fbs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fbs_pkg::BYTE_W-1:0]    cfg_data_i
);

  fbs_pkg::cfg_t  cfg_q;
  fbs_pkg::hs_t   push_hs;
  fbs_pkg::item_t push_item, pop_item;
  logic           push_ready, pop_valid, pop_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_byte         <= fbs_pkg::FLAG_RESET;
      cfg_q.escape_byte       <= fbs_pkg::ESCAPE_RESET;
      cfg_q.flag_substitute   <= fbs_pkg::FLAG_SUBST_RESET;
      cfg_q.escape_substitute <= fbs_pkg::ESCAPE_SUBST_RESET;
    end else if (cfg_we_i) begin
      case (fbs_pkg::cfg_idx_e'(cfg_idx_i))
        fbs_pkg::CFG_FLAG:         cfg_q.flag_byte         <= cfg_data_i;
        fbs_pkg::CFG_ESCAPE:       cfg_q.escape_byte       <= cfg_data_i;
        fbs_pkg::CFG_FLAG_SUBST:   cfg_q.flag_substitute   <= cfg_data_i;
        fbs_pkg::CFG_ESCAPE_SUBST: cfg_q.escape_substitute <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_hs_o    (push_hs),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  fbs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_hs.valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  fbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // The second half of an escaped pair is ready in the cycle after the first is taken.
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.run_end |=> out_o.valid && out_o.run_end)
    else $error("escaped pair not completed back to back");

  // The last byte of a frame is never split into a pair.
  a_end_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.out_frame_end |-> out_o.run_end)
    else $error("frame end on the first half of a pair");

  // Input is taken only while the queue has room.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |-> push_hs.ready && push_hs.valid)
    else $error("input transfer without queue room");
`endif

endmodule
